// File: rtl/triangle_unit_normal_defines.svh
// Assertion macros used by the checker file, tun_check.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TUN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TUN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/tun_pkg.sv
package tun_pkg;

   // Coordinate width; it sets the field widths of the request struct.
   localparam int COORD_BITS    = 24;
   localparam int FRAC_BITS_DEF = 30;

   // The largest normalized magnitude lies in [2^61, 2^62).
   localparam int NORM_BITS = 62;
   localparam int HALF_BITS = NORM_BITS / 2;
   localparam int SQ_BITS   = 2 * NORM_BITS;
   localparam int SUM_BITS  = SQ_BITS + 2;
   localparam int ROOT_BITS = SUM_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 3;
   localparam int DEN_BITS  = ROOT_BITS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] a_z;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] b_z;
      logic signed [COORD_BITS-1:0] c_x;
      logic signed [COORD_BITS-1:0] c_y;
      logic signed [COORD_BITS-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               degenerate;
   } rsp_type;

   // Per-item flags carried alongside the datapath.
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } side_type;

endpackage

// File: rtl/triangle_unit_normal.sv
// Triangle unit normal. Takes one triangle (three vertices, counter-clockwise, signed
// integer coordinates) per request and returns the face normal scaled to unit length in
// signed Q1.FRAC_BITS, rounded half away from zero, plus a degenerate flag (zero area,
// normal all zero). Fully pipelined: a new request is taken every cycle unless rsp_stall
// holds a finished result. The pipe includes the 63-stage bit-per-stage square root and
// the FRAC_BITS+1 stage restoring divider that follows it. rsp_stall freezes the whole
// pipe, so req_stall is high exactly while a result waits with rsp_stall high.
module triangle_unit_normal #(
   parameter int FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tun_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tun_pkg::rsp_type rsp_data
);

   localparam int C   = tun_pkg::COORD_BITS;
   localparam int CW  = C + 1;
   localparam int XW  = 2 * CW;
   localparam int NB  = tun_pkg::NORM_BITS;
   localparam int HB  = tun_pkg::HALF_BITS;
   localparam int QW  = 2 * HB;
   localparam int SQW = tun_pkg::SQ_BITS;
   localparam int SW  = tun_pkg::SUM_BITS;
   localparam int QB  = FRAC_BITS + 1;
   localparam int NG  = (XW + 7) / 8;
   localparam int OW  = NG * 8;
   localparam int LW  = $clog2(XW + 1);
   localparam int SAW = (LW > 7) ? LW : 7;
   localparam int SHW = XW + NB;

   // Whole pipe moves unless a finished result is held off
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: edge vectors
   logic                 e_vld_ff;
   logic signed [CW-1:0] eu_in [3];
   logic signed [CW-1:0] ev_in [3];
   logic signed [CW-1:0] eu_ff [3];
   logic signed [CW-1:0] ev_ff [3];

   always_comb begin
      eu_in[0] = {req_data.b_x[C-1], req_data.b_x} - {req_data.a_x[C-1], req_data.a_x};
      eu_in[1] = {req_data.b_y[C-1], req_data.b_y} - {req_data.a_y[C-1], req_data.a_y};
      eu_in[2] = {req_data.b_z[C-1], req_data.b_z} - {req_data.a_z[C-1], req_data.a_z};
      ev_in[0] = {req_data.c_x[C-1], req_data.c_x} - {req_data.a_x[C-1], req_data.a_x};
      ev_in[1] = {req_data.c_y[C-1], req_data.c_y} - {req_data.a_y[C-1], req_data.a_y};
      ev_in[2] = {req_data.c_z[C-1], req_data.c_z} - {req_data.a_z[C-1], req_data.a_z};
   end

   // Stage 2: the six cross-product terms
   logic                 p_vld_ff;
   logic signed [XW-1:0] p_in [6];
   logic signed [XW-1:0] p_ff [6];

   always_comb begin
      p_in[0] = XW'(eu_ff[1]) * XW'(ev_ff[2]);
      p_in[1] = XW'(eu_ff[2]) * XW'(ev_ff[1]);
      p_in[2] = XW'(eu_ff[2]) * XW'(ev_ff[0]);
      p_in[3] = XW'(eu_ff[0]) * XW'(ev_ff[2]);
      p_in[4] = XW'(eu_ff[0]) * XW'(ev_ff[1]);
      p_in[5] = XW'(eu_ff[1]) * XW'(ev_ff[0]);
   end

   // Stage 3: cross product
   logic                 x_vld_ff;
   logic signed [XW-1:0] x_ff [3];

   // Stage 4: magnitude and sign
   logic                 a_vld_ff;
   logic [XW-1:0]        mag_in [3];
   logic [XW-1:0]        a_mag_ff [3];
   logic [2:0]           a_neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = x_ff[i][XW-1] ? XW'(-x_ff[i]) : XW'(x_ff[i]);
      end
   end

   // Stage 5: leading-one search, per byte group
   logic                 g_vld_ff;
   logic [OW-1:0]        grp_or;
   logic [NG-1:0]        grp_any_in;
   logic [2:0]           grp_pos_in [NG];
   logic [NG-1:0]        grp_any_ff;
   logic [2:0]           grp_pos_ff [NG];
   logic [XW-1:0]        g_mag_ff [3];
   logic [2:0]           g_neg_ff;

   always_comb begin
      grp_or = OW'(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
      for (int k = 0; k < NG; k++) begin
         grp_any_in[k] = |grp_or[k*8 +: 8];
         grp_pos_in[k] = '0;
         for (int b = 0; b < 8; b++) begin
            if (grp_or[k*8 + b]) begin
               grp_pos_in[k] = 3'(b);
            end
         end
      end
   end

   // Stage 6: bit length of the largest magnitude
   logic                 l_vld_ff;
   logic [LW-1:0]        len_in;
   logic [LW-1:0]        len_ff;
   logic [XW-1:0]        l_mag_ff [3];
   logic [2:0]           l_neg_ff;

   always_comb begin
      len_in = '0;
      for (int k = 0; k < NG; k++) begin
         if (grp_any_ff[k]) begin
            len_in = LW'(k * 8 + int'(grp_pos_ff[k]) + 1);
         end
      end
   end

   // Stage 7: common shift so the largest lands in [2^61, 2^62)
   logic                 n_vld_ff;
   logic [SAW-1:0]       len_w;
   logic [SHW-1:0]       wide [3];
   logic [NB-1:0]        m_in [3];
   logic [NB-1:0]        m_ff [3];
   tun_pkg::side_type    n_side_ff;

   always_comb begin
      len_w = SAW'(len_ff);
      for (int i = 0; i < 3; i++) begin
         wide[i] = SHW'(l_mag_ff[i]);
         if (len_w > SAW'(NB)) begin
            m_in[i] = NB'(wide[i] >> (len_w - SAW'(NB)));
         end else begin
            m_in[i] = NB'(wide[i] << (SAW'(NB) - len_w));
         end
      end
   end

   // Stage 8: partial products of the squares
   logic                 q_vld_ff;
   logic [QW-1:0]        hh_ff [3];
   logic [QW-1:0]        hl_ff [3];
   logic [QW-1:0]        ll_ff [3];
   logic [2:0][NB-1:0]   q_m_ff;
   tun_pkg::side_type    q_side_ff;

   // Stage 9: per-component squares
   logic                 r_vld_ff;
   logic [SQW-1:0]       sq_in [3];
   logic [SQW-1:0]       sq_ff [3];
   logic [2:0][NB-1:0]   r_m_ff;
   tun_pkg::side_type    r_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (SQW'(hh_ff[i]) << (2 * HB)) + (SQW'(hl_ff[i]) << (HB + 1))
                  + SQW'(ll_ff[i]);
      end
   end

   // Stage 10: sum of squares
   logic                 s_vld_ff;
   logic [SW-1:0]        s_ff;
   logic [2:0][NB-1:0]   s_m_ff;
   tun_pkg::side_type    s_side_ff;

   // Control: valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         x_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         l_vld_ff <= 1'b0;
         n_vld_ff <= 1'b0;
         q_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= req_valid;
         p_vld_ff <= e_vld_ff;
         x_vld_ff <= p_vld_ff;
         a_vld_ff <= x_vld_ff;
         g_vld_ff <= a_vld_ff;
         l_vld_ff <= g_vld_ff;
         n_vld_ff <= l_vld_ff;
         q_vld_ff <= n_vld_ff;
         r_vld_ff <= q_vld_ff;
         s_vld_ff <= r_vld_ff;
      end
   end

   // Datapath registers of the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         eu_ff      <= eu_in;
         ev_ff      <= ev_in;
         p_ff       <= p_in;
         x_ff[0]    <= p_ff[0] - p_ff[1];
         x_ff[1]    <= p_ff[2] - p_ff[3];
         x_ff[2]    <= p_ff[4] - p_ff[5];
         a_mag_ff   <= mag_in;
         a_neg_ff   <= {x_ff[2][XW-1], x_ff[1][XW-1], x_ff[0][XW-1]};
         grp_any_ff <= grp_any_in;
         grp_pos_ff <= grp_pos_in;
         g_mag_ff   <= a_mag_ff;
         g_neg_ff   <= a_neg_ff;
         len_ff     <= len_in;
         l_mag_ff   <= g_mag_ff;
         l_neg_ff   <= g_neg_ff;
         m_ff       <= m_in;
         n_side_ff.neg   <= l_neg_ff;
         n_side_ff.degen <= (len_ff == '0);
         for (int i = 0; i < 3; i++) begin
            hh_ff[i]  <= QW'(m_ff[i][NB-1:HB]) * QW'(m_ff[i][NB-1:HB]);
            hl_ff[i]  <= QW'(m_ff[i][NB-1:HB]) * QW'(m_ff[i][HB-1:0]);
            ll_ff[i]  <= QW'(m_ff[i][HB-1:0]) * QW'(m_ff[i][HB-1:0]);
            q_m_ff[i] <= m_ff[i];
         end
         q_side_ff <= n_side_ff;
         sq_ff     <= sq_in;
         r_m_ff    <= q_m_ff;
         r_side_ff <= q_side_ff;
         s_ff      <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         s_m_ff    <= r_m_ff;
         s_side_ff <= r_side_ff;
      end
   end

   // Square root and division back end
   logic                 bd_valid;
   logic [2:0][QB-1:0]   bd_q;
   tun_pkg::side_type    bd_side;

   tun_root_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_root_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_vld_ff),
      .in_s      (s_ff),
      .in_m      (s_m_ff),
      .in_side   (s_side_ff),
      .out_valid (bd_valid),
      .out_q     (bd_q),
      .out_side  (bd_side)
   );

   // Output register: apply sign, zero the normal on zero area
   logic             rsp_valid_ff;
   tun_pkg::rsp_type rsp_in;
   tun_pkg::rsp_type rsp_ff;
   logic [31:0]      comp [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (bd_side.degen) begin
            comp[i] = '0;
         end else if (bd_side.neg[i]) begin
            comp[i] = -32'(bd_q[i]);
         end else begin
            comp[i] = 32'(bd_q[i]);
         end
      end
      rsp_in.normal_x   = comp[0];
      rsp_in.normal_y   = comp[1];
      rsp_in.normal_z   = comp[2];
      rsp_in.degenerate = bd_side.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= bd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/tun_root_div.sv
module tun_root_div #(
   parameter int FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        in_valid,
   input  logic [tun_pkg::SUM_BITS-1:0]                in_s,
   input  logic [2:0][tun_pkg::NORM_BITS-1:0]          in_m,
   input  tun_pkg::side_type                           in_side,
   output logic                                        out_valid,
   output logic [2:0][FRAC_BITS:0]                     out_q,
   output tun_pkg::side_type                           out_side
);

   localparam int RB = tun_pkg::ROOT_BITS;
   localparam int RW = tun_pkg::REM_BITS;
   localparam int SW = tun_pkg::SUM_BITS;
   localparam int NB = tun_pkg::NORM_BITS;
   localparam int DW = tun_pkg::DEN_BITS;
   localparam int QB = FRAC_BITS + 1;
   localparam int NW = FRAC_BITS + 64;

   // Square root: one result bit per stage
   logic                 rt_vld_ff  [RB];
   logic [RB-1:0]        rt_root_ff [RB];
   logic [RW-1:0]        rt_rem_ff  [RB];
   logic [SW-1:0]        rt_s_ff    [RB];
   logic [2:0][NB-1:0]   rt_m_ff    [RB];
   tun_pkg::side_type    rt_side_ff [RB];

   genvar g;
   generate
      for (g = 0; g < RB; g++) begin : g_root
         localparam int K = RB - 1 - g;
         logic               prev_vld;
         logic [RB-1:0]      prev_root;
         logic [RW-1:0]      prev_rem;
         logic [SW-1:0]      prev_s;
         logic [2:0][NB-1:0] prev_m;
         tun_pkg::side_type  prev_side;
         logic [RW-1:0]      part;
         logic [RW-1:0]      trial;
         logic               fits;
         logic [RW-1:0]      rem_in;
         logic [RB-1:0]      root_in;

         if (g == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_root = '0;
            assign prev_rem  = '0;
            assign prev_s    = in_s;
            assign prev_m    = in_m;
            assign prev_side = in_side;
         end else begin : g_next
            assign prev_vld  = rt_vld_ff[g-1];
            assign prev_root = rt_root_ff[g-1];
            assign prev_rem  = rt_rem_ff[g-1];
            assign prev_s    = rt_s_ff[g-1];
            assign prev_m    = rt_m_ff[g-1];
            assign prev_side = rt_side_ff[g-1];
         end

         // Bring down two radicand bits and try root*4+1
         always_comb begin
            part    = {prev_rem[RW-3:0], prev_s[2*K+1 -: 2]};
            trial   = RW'({prev_root, 2'b01});
            fits    = (part >= trial);
            rem_in  = fits ? (part - trial) : part;
            root_in = {prev_root[RB-2:0], fits};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               rt_vld_ff[g] <= 1'b0;
            end else if (adv) begin
               rt_vld_ff[g] <= prev_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rt_root_ff[g] <= root_in;
               rt_rem_ff[g]  <= rem_in;
               rt_s_ff[g]    <= prev_s;
               rt_m_ff[g]    <= prev_m;
               rt_side_ff[g] <= prev_side;
            end
         end
      end
   endgenerate

   // Numerator m*2^(F+1)+R and denominator 2R
   logic                 nm_vld_ff;
   logic [2:0][NW-1:0]   nm_n_ff;
   logic [2:0][NW-1:0]   nm_n_in;
   logic [DW-1:0]        nm_d_ff;
   tun_pkg::side_type    nm_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_n_in[i] = (NW'(rt_m_ff[RB-1][i]) << QB) + NW'(rt_root_ff[RB-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff <= 1'b0;
      end else if (adv) begin
         nm_vld_ff <= rt_vld_ff[RB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_n_ff    <= nm_n_in;
         nm_d_ff    <= {rt_root_ff[RB-1], 1'b0};
         nm_side_ff <= rt_side_ff[RB-1];
      end
   end

   // Restoring division: one quotient bit per stage, three lanes
   logic                 dv_vld_ff  [QB];
   logic [2:0][DW-1:0]   dv_rem_ff  [QB];
   logic [2:0][QB-1:0]   dv_q_ff    [QB];
   logic [2:0][QB-1:0]   dv_n_ff    [QB];
   logic [DW-1:0]        dv_d_ff    [QB];
   tun_pkg::side_type    dv_side_ff [QB];

   genvar j;
   generate
      for (j = 0; j < QB; j++) begin : g_div
         localparam int BI = QB - 1 - j;
         logic               prev_vld;
         logic [2:0][DW-1:0] prev_rem;
         logic [2:0][QB-1:0] prev_q;
         logic [2:0][QB-1:0] prev_n;
         logic [DW-1:0]      prev_d;
         tun_pkg::side_type  prev_side;
         logic [2:0][DW:0]   part;
         logic [2:0][DW:0]   diff;
         logic [2:0]         fits;
         logic [2:0][DW-1:0] rem_in;
         logic [2:0][QB-1:0] q_in;

         if (j == 0) begin : g_first
            assign prev_vld  = nm_vld_ff;
            assign prev_d    = nm_d_ff;
            assign prev_side = nm_side_ff;
            assign prev_q    = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
               assign prev_rem[l] = DW'(nm_n_ff[l][NW-1:QB]);
               assign prev_n[l]   = nm_n_ff[l][QB-1:0];
            end
         end else begin : g_next
            assign prev_vld  = dv_vld_ff[j-1];
            assign prev_rem  = dv_rem_ff[j-1];
            assign prev_q    = dv_q_ff[j-1];
            assign prev_n    = dv_n_ff[j-1];
            assign prev_d    = dv_d_ff[j-1];
            assign prev_side = dv_side_ff[j-1];
         end

         always_comb begin
            for (int l = 0; l < 3; l++) begin
               part[l]   = {prev_rem[l], prev_n[l][BI]};
               diff[l]   = part[l] - {1'b0, prev_d};
               fits[l]   = (part[l] >= {1'b0, prev_d});
               rem_in[l] = fits[l] ? diff[l][DW-1:0] : part[l][DW-1:0];
               q_in[l]   = prev_q[l] | (QB'(fits[l]) << BI);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dv_vld_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_vld_ff[j] <= prev_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j]  <= rem_in;
               dv_q_ff[j]    <= q_in;
               dv_n_ff[j]    <= prev_n;
               dv_d_ff[j]    <= prev_d;
               dv_side_ff[j] <= prev_side;
            end
         end
      end
   endgenerate

   assign out_valid = dv_vld_ff[QB-1];
   assign out_q     = dv_q_ff[QB-1];
   assign out_side  = dv_side_ff[QB-1];

endmodule

// File: rtl/tun_check.sv
`include "triangle_unit_normal_defines.svh"

module tun_check #(
   parameter int FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tun_pkg::rsp_type rsp_data
);

   localparam logic signed [31:0] UNIT     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] NEG_UNIT = -UNIT;

   // Zero-area result carries an all-zero normal
   `TUN_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.normal_x == 0 && rsp_data.normal_y == 0 && rsp_data.normal_z == 0)

   // Every component stays within [-1.0, 1.0]
   `TUN_ASSERT_IMPLY(a_unit_range, clock, reset, rsp_valid, rsp_data.normal_x <= UNIT && rsp_data.normal_x >= NEG_UNIT && rsp_data.normal_y <= UNIT && rsp_data.normal_y >= NEG_UNIT && rsp_data.normal_z <= UNIT && rsp_data.normal_z >= NEG_UNIT)

   // Held result does not change
   `TUN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Requests are held off exactly while a result is held off
   `TUN_ASSERT_IMPLY(a_backpressure, clock, reset, req_valid || !req_valid, req_stall == (rsp_valid && rsp_stall))

endmodule

bind triangle_unit_normal tun_check #(.FRAC_BITS(FRAC_BITS)) u_tun_check (.*);

// File: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC     = tun_pkg::FRAC_BITS_DEF;
   localparam int LATENCY  = 76 + FRAC;
   localparam int N_RANDOM = 400;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic signed [31:0] ONE = 32'sd1 << FRAC;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tun_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tun_pkg::rsp_type rsp_data;

   triangle_unit_normal dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   tun_pkg::rsp_type normals_due[$];
   int      mismatches = 0;
   longint  cycle_count = 0;
   bit      hold_off = 1'b0;

   // Integer square root, floor, of a 128-bit value.
   function automatic logic [127:0] root_floor(logic [127:0] s);
      logic [127:0] res, bit_v, t;
      res = '0;
      bit_v = 128'd1 << 126;
      while (bit_v > s) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         t = res + bit_v;
         if (s >= t) begin
            s = s - t;
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Face normal: cross product of the edge vectors b-a and c-a, scaled to unit length.
   function automatic tun_pkg::rsp_type face_normal(tun_pkg::req_type t);
      logic signed [127:0] u [3], v [3], x [3];
      logic [127:0] m [3], all, s, r, num, q;
      logic [2:0] neg;
      int len;
      tun_pkg::rsp_type o;
      u[0] = 128'(t.b_x) - 128'(t.a_x);
      u[1] = 128'(t.b_y) - 128'(t.a_y);
      u[2] = 128'(t.b_z) - 128'(t.a_z);
      v[0] = 128'(t.c_x) - 128'(t.a_x);
      v[1] = 128'(t.c_y) - 128'(t.a_y);
      v[2] = 128'(t.c_z) - 128'(t.a_z);
      x[0] = u[1] * v[2] - u[2] * v[1];
      x[1] = u[2] * v[0] - u[0] * v[2];
      x[2] = u[0] * v[1] - u[1] * v[0];
      o = '0;
      all = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = x[i] < 0;
         m[i] = neg[i] ? -x[i] : x[i];
         all = all | m[i];
      end
      if (all == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      len = 0;
      for (int i = 0; i < 128; i++) if (all[i]) len = i + 1;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = len > 62 ? m[i] >> (len - 62) : m[i] << (62 - len);
         s = s + m[i] * m[i];
      end
      r = root_floor(s);
      for (int i = 0; i < 3; i++) begin
         num = (m[i] << (FRAC + 1)) + r;
         q = num / (r << 1);
         if (neg[i]) q = -q;
         if (i == 0) o.normal_x = q[31:0];
         if (i == 1) o.normal_y = q[31:0];
         if (i == 2) o.normal_z = q[31:0];
      end
      return o;
   endfunction

   function automatic tun_pkg::req_type tri_of(int ax, int ay, int az, int bx, int by,
                                               int bz, int cx, int cy, int cz);
      tun_pkg::req_type t;
      t.a_x = 24'(ax); t.a_y = 24'(ay); t.a_z = 24'(az);
      t.b_x = 24'(bx); t.b_y = 24'(by); t.b_z = 24'(bz);
      t.c_x = 24'(cx); t.c_y = 24'(cy); t.c_z = 24'(cz);
      return t;
   endfunction

   // Random triangle: mostly full range, some small or near-degenerate.
   function automatic tun_pkg::req_type random_tri();
      tun_pkg::req_type t;
      int mode;
      t.a_x = 24'($urandom); t.a_y = 24'($urandom); t.a_z = 24'($urandom);
      t.b_x = 24'($urandom); t.b_y = 24'($urandom); t.b_z = 24'($urandom);
      t.c_x = 24'($urandom); t.c_y = 24'($urandom); t.c_z = 24'($urandom);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
      end else if (mode == 1) begin
         t.c_x = 24'(2 * t.b_x - t.a_x);
         t.c_y = 24'(2 * t.b_y - t.a_y);
         t.c_z = 24'(2 * t.b_z - t.a_z);
      end else if (mode <= 3) begin
         t.a_x = $signed(t.a_x) >>> 16; t.a_y = $signed(t.a_y) >>> 16;
         t.a_z = $signed(t.a_z) >>> 16; t.b_x = $signed(t.b_x) >>> 16;
         t.b_y = $signed(t.b_y) >>> 16; t.b_z = $signed(t.b_z) >>> 16;
         t.c_x = $signed(t.c_x) >>> 16; t.c_y = $signed(t.c_y) >>> 16;
         t.c_z = $signed(t.c_z) >>> 16;
      end
      return t;
   endfunction

   // Drive one request and wait until it is taken.
   task automatic send_tri(tun_pkg::req_type t, bit has_known, tun_pkg::rsp_type known);
      req_valid <= 1'b1;
      req_data  <= t;
      normals_due.push_back(has_known ? known : face_normal(t));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Bursts with random gaps; valid drops only between bursts.
   task automatic gap();
      int n;
      if ($urandom_range(0, 3) != 0) return;
      req_valid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clock);
   endtask

   // Directed table: expected typed in where obvious, else predicted.
   typedef struct {
      tun_pkg::req_type tri_in;
      bit               has_known;
      tun_pkg::rsp_type known;
   } tri_row_type;

   localparam int MAXC = 8388607;
   localparam int MINC = -8388608;

   initial begin
      tri_row_type      rows [$];
      tun_pkg::rsp_type zero_out, z_up, x_up, y_up;
      tun_pkg::req_type t;
      zero_out = '0; zero_out.degenerate = 1'b1;
      z_up = '0; z_up.normal_z = ONE;
      x_up = '0; x_up.normal_x = ONE;
      y_up = '0; y_up.normal_y = ONE;
      rows.push_back('{tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_out});
      rows.push_back('{tri_of(5, 5, 5, 5, 5, 5, 9, 1, 3), 1, zero_out});
      rows.push_back('{tri_of(0, 0, 0, 1, 1, 1, 2, 2, 2), 1, zero_out});
      rows.push_back('{tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, z_up});
      rows.push_back('{tri_of(0, 0, 0, 0, 1, 0, 0, 0, 1), 1, x_up});
      rows.push_back('{tri_of(0, 0, 0, 0, 0, 1, 1, 0, 0), 1, y_up});
      rows.push_back('{tri_of(0, 0, 0, 0, 1, 0, 1, 0, 0), 0, zero_out});
      rows.push_back('{tri_of(MINC, MINC, 0, MAXC, MINC, 0, MINC, MAXC, 0), 1, z_up});
      rows.push_back('{tri_of(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC),
                       1, zero_out});
      rows.push_back('{tri_of(MINC, MINC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC), 0,
                       zero_out});
      rows.push_back('{tri_of(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC), 0,
                       zero_out});
      rows.push_back('{tri_of(1, 2, 3, 4, 5, 6, 7, 8, 10), 0, zero_out});
      rows.push_back('{tri_of(0, 0, 0, 1, 1, 0, -1, 1, 1), 0, zero_out});
      rows.push_back('{tri_of(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1, zero_out});
      rows.push_back('{tri_of(0, 0, 0, MAXC, 0, 0, 0, 1, 0), 1, z_up});
      rows.push_back('{tri_of(0, 0, 0, MAXC, 1, 0, 1, MAXC, 0), 0, zero_out});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_tri(rows[i].tri_in, rows[i].has_known, rows[i].known);
         gap();
      end

      // Long receiver hold-off while requests keep coming.
      hold_off = 1'b1;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 200) hold_off = 1'b0;
         t = random_tri();
         send_tri(t, 1'b0, zero_out);
         if (i > 200 && i % 50 < 20) continue;
         gap();
      end
      req_valid <= 1'b0;

      while (normals_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && normals_due.size() == 0) begin
         $display("triangle_unit_normal regression: pass");
      end else begin
         $display("triangle_unit_normal regression: fail");
      end
      $finish;
   end

   // Receiver stall pattern plus the long hold-off.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_off && hold < 300) begin
            hold++;
            rsp_stall <= 1'b1;
         end else if (cycle_count % 1000 < 300) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // Result check against oldest expectation.
   always @(posedge clock) begin
      tun_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected normal %p", rsp_data);
         end else begin
            want = normals_due.pop_front();
            if (rsp_data.normal_x !== want.normal_x || rsp_data.normal_y !== want.normal_y ||
                rsp_data.normal_z !== want.normal_z ||
                rsp_data.degenerate !== want.degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("triangle_unit_normal regression: fail");
         $finish;
      end
   end

endmodule
